>>> hw/rtl/pfvc_pkg.sv
// Shared types and constants of the PID force and velocity controller.
package pfvc_pkg;

    localparam int POS_W       = 32;
    localparam int OUT_W       = 32;
    localparam int CFG_W       = 32;
    localparam int GAIN_W      = 32;
    localparam int TGT_W       = 31;
    localparam int CFG_IDX_W   = 3;
    localparam int CHUNK_W     = 16;
    localparam int CHUNK_IDX_W = 2;
    localparam int STEP_FRAC   = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 3'd4;

    typedef enum logic [1:0] {
        PH_INTEG,
        PH_PROP,
        PH_DERIV,
        PH_STEP
    } t_phase;

    typedef struct packed {
        logic                   load;
        logic                   mac_en;
        logic                   mac_first;
        logic [CHUNK_IDX_W-1:0] chunk;
        logic                   post_en;
        logic                   wb_en;
        t_phase                 phase;
    } t_dp_cmd;

endpackage

>>> hw/rtl/pfvc_ctrl.sv
// Sequencing state machine of the PID force and velocity controller.
module pfvc_ctrl
    import pfvc_pkg::*;
#(
    parameter int NCH = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_POST,
        S_WB
    } t_state;

    localparam logic [CHUNK_IDX_W-1:0] TOP_CHUNK = CHUNK_IDX_W'(NCH - 1);

    t_state                 r_state, n_state;
    t_phase                 r_phase, n_phase;
    logic [CHUNK_IDX_W-1:0] r_chunk, n_chunk;
    logic                   r_out_valid, n_out_valid;
    logic                   accept, wb_go;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = o_in_ready && i_in_valid;
    assign wb_go      = (r_state == S_WB) &&
                        ((r_phase != PH_STEP) || !r_out_valid || i_out_ready);

    always_comb begin
        o_cmd.load      = accept;
        o_cmd.mac_en    = (r_state == S_MUL);
        o_cmd.mac_first = (r_chunk == TOP_CHUNK);
        o_cmd.chunk     = r_chunk;
        o_cmd.post_en   = (r_state == S_POST);
        o_cmd.wb_en     = wb_go;
        o_cmd.phase     = r_phase;
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_chunk     = r_chunk;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_MUL;
                    n_phase = PH_INTEG;
                    n_chunk = TOP_CHUNK;
                end
            end
            S_MUL: begin
                if (r_chunk == '0) begin
                    n_state = S_POST;
                end else begin
                    n_chunk = r_chunk - 1'b1;
                end
            end
            S_POST: begin
                n_state = S_WB;
            end
            S_WB: begin
                if (wb_go) begin
                    n_chunk = TOP_CHUNK;
                    n_state = S_MUL;
                    case (r_phase)
                        PH_INTEG: n_phase = PH_PROP;
                        PH_PROP:  n_phase = PH_DERIV;
                        PH_DERIV: n_phase = PH_STEP;
                        PH_STEP: begin
                            n_state     = S_IDLE;
                            n_out_valid = 1'b1;
                        end
                        default:  n_phase = PH_INTEG;
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_INTEG;
            r_chunk     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_chunk     <= n_chunk;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_MUL) && (r_phase == PH_INTEG) && (r_chunk == TOP_CHUNK))
        else $error("accepted transfer did not start the integral product");
    a_chunk_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) && (r_chunk != '0) |=>
        (r_state == S_MUL) && (r_chunk == $past(r_chunk) - 1'b1))
        else $error("multiplier chunk sequence broken");
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past((r_state == S_WB) && (r_phase == PH_STEP)))
        else $error("result raised outside the velocity write-back");
`endif

endmodule

>>> hw/rtl/pfvc_dp.sv
// Datapath of the PID force and velocity controller: registers, shared multiplier, adders.
module pfvc_dp
    import pfvc_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    parameter int NCH        = 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic signed [POS_W-1:0] i_pos,
    input  t_dp_cmd                 i_cmd,
    output logic [OUT_W-1:0]        o_vel,
    output logic                    o_sat
);

    localparam int DW   = DATA_WIDTH;
    localparam int XP_W = NCH * CHUNK_W;
    localparam int GW   = GAIN_W + 1;
    localparam int MW   = CHUNK_W + 1;
    localparam int PW   = XP_W + GW;
    localparam int WW   = ((DW > TGT_W + 2) ? DW : TGT_W + 2) + 1;

    logic [TGT_W-1:0]  r_target, r_prop, r_integ_g, r_deriv;
    logic [GAIN_W-1:0] r_step_g;

    logic signed [DW-1:0] r_integ, r_vel, r_prev;
    logic signed [DW-1:0] r_err, r_pterm, r_force, r_mres;
    logic signed [PW-1:0] r_macc;
    logic                 r_flag;
    logic [OUT_W-1:0]     r_out_vel;
    logic                 r_out_sat;

    logic signed [WW-1:0]   diff;
    logic                   diff_fit;
    logic signed [DW-1:0]   err_c;

    logic signed [DW-1:0]   x_sel;
    logic [GAIN_W-1:0]      g_sel;
    logic signed [XP_W-1:0] xp;
    logic [CHUNK_W-1:0]     chunk;
    logic signed [MW-1:0]   mop;
    logic signed [GW-1:0]   gop;
    logic signed [MW+GW-1:0] partial;
    logic signed [PW-1:0]   macc_next;

    logic signed [PW-1:0]   shifted;
    logic                   sh_fit;
    logic signed [DW-1:0]   mres_c;

    logic signed [DW:0]     isum;
    logic                   isum_fit;
    logic signed [DW-1:0]   integ_c;
    logic signed [DW+1:0]   fsum;
    logic                   fsum_fit;
    logic signed [DW-1:0]   force_c;
    logic signed [DW+1:0]   vsum;
    logic                   vsum_fit;
    logic signed [DW-1:0]   vel_c;

    // Saturation: a sum fits when all bits from the sign position upwards agree.
    assign diff     = WW'(signed'({1'b0, r_target})) - WW'(i_pos);
    assign diff_fit = (&diff[WW-1:DW-1]) | ~(|diff[WW-1:DW-1]);
    assign err_c    = diff_fit ? diff[DW-1:0] : {diff[WW-1], {(DW-1){~diff[WW-1]}}};

    always_comb begin
        case (i_cmd.phase)
            PH_INTEG: begin
                x_sel = r_err;
                g_sel = GAIN_W'(r_integ_g);
            end
            PH_PROP: begin
                x_sel = r_err;
                g_sel = GAIN_W'(r_prop);
            end
            PH_DERIV: begin
                x_sel = r_vel;
                g_sel = GAIN_W'(r_deriv);
            end
            PH_STEP: begin
                x_sel = r_force;
                g_sel = r_step_g;
            end
            default: begin
                x_sel = r_err;
                g_sel = '0;
            end
        endcase
    end

    // The top chunk carries the sign; lower chunks are unsigned digits.
    assign xp        = XP_W'(x_sel);
    assign chunk     = xp[i_cmd.chunk * CHUNK_W +: CHUNK_W];
    assign mop       = {i_cmd.mac_first ? chunk[CHUNK_W-1] : 1'b0, chunk};
    assign gop       = {1'b0, g_sel};
    assign partial   = mop * gop;
    assign macc_next = i_cmd.mac_first ? PW'(partial)
                                       : (r_macc <<< CHUNK_W) + PW'(partial);

    assign shifted = (i_cmd.phase == PH_STEP) ? (r_macc >>> STEP_FRAC)
                                              : (r_macc >>> FRAC_BITS);
    assign sh_fit  = (&shifted[PW-1:DW-1]) | ~(|shifted[PW-1:DW-1]);
    assign mres_c  = sh_fit ? shifted[DW-1:0]
                            : {shifted[PW-1], {(DW-1){~shifted[PW-1]}}};

    assign isum     = (DW+1)'(r_integ) + (DW+1)'(r_mres);
    assign isum_fit = (isum[DW] == isum[DW-1]);
    assign integ_c  = isum_fit ? isum[DW-1:0] : {isum[DW], {(DW-1){~isum[DW]}}};

    assign fsum     = (DW+2)'(r_pterm) - (DW+2)'(r_mres) + (DW+2)'(r_integ);
    assign fsum_fit = (&fsum[DW+1:DW-1]) | ~(|fsum[DW+1:DW-1]);
    assign force_c  = fsum_fit ? fsum[DW-1:0] : {fsum[DW+1], {(DW-1){~fsum[DW+1]}}};

    assign vsum     = (DW+2)'(r_vel) + (DW+2)'(r_prev) + (DW+2)'(r_mres);
    assign vsum_fit = (&vsum[DW+1:DW-1]) | ~(|vsum[DW+1:DW-1]);
    assign vel_c    = vsum_fit ? vsum[DW-1:0] : {vsum[DW+1], {(DW-1){~vsum[DW+1]}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= '0;
            r_prop    <= '0;
            r_integ_g <= '0;
            r_deriv   <= '0;
            r_step_g  <= '0;
            r_integ   <= '0;
            r_vel     <= '0;
            r_prev    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TARGET: r_target  <= i_cfg_data[TGT_W-1:0];
                    CFG_PROP:   r_prop    <= i_cfg_data[TGT_W-1:0];
                    CFG_INTEG:  r_integ_g <= i_cfg_data[TGT_W-1:0];
                    CFG_DERIV:  r_deriv   <= i_cfg_data[TGT_W-1:0];
                    CFG_STEP:   r_step_g  <= i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.wb_en && (i_cmd.phase == PH_INTEG)) begin
                r_integ <= integ_c;
            end
            if (i_cmd.wb_en && (i_cmd.phase == PH_STEP)) begin
                r_vel  <= vel_c;
                r_prev <= r_mres;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_err  <= err_c;
            r_flag <= ~diff_fit;
        end
        if (i_cmd.mac_en) begin
            r_macc <= macc_next;
        end
        if (i_cmd.post_en) begin
            r_mres <= mres_c;
            r_flag <= r_flag | ~sh_fit;
        end
        if (i_cmd.wb_en) begin
            case (i_cmd.phase)
                PH_INTEG: r_flag <= r_flag | ~isum_fit;
                PH_PROP:  r_pterm <= r_mres;
                PH_DERIV: begin
                    r_force <= force_c;
                    r_flag  <= r_flag | ~fsum_fit;
                end
                PH_STEP: begin
                    r_out_vel <= OUT_W'(vel_c);
                    r_out_sat <= r_flag | ~vsum_fit;
                end
                default: ;
            endcase
        end
    end

    assign o_vel = r_out_vel;
    assign o_sat = r_out_sat;

endmodule

>>> hw/rtl/pid_force_velocity_controller.sv
// Top level of the PID force controller with trapezoidal velocity integration.
//
// Each transfer on the slave stream is one control tick carrying a measured
// position (signed Q16.16). The block forms the position error, updates the
// integral, forms the force, scales it into a velocity step and integrates
// the velocity command by the trapezoidal rule. One result transfer follows
// each input transfer: the velocity command in tdata and a saturation flag
// in tuser. Gains and the target are written on the plain register port
// while the block is idle.
// One shared multiplier takes 16 bits of the signal operand per cycle, so
// each of the four products is formed in NCH = ceil(DATA_WIDTH / 16) chunk
// steps, followed by a shift-and-clip step and a write-back step. A new tick
// is accepted only after the velocity write-back of the previous one.
// The result sits in an output register, so the next tick is accepted and
// processed while it waits; a stalled receiver only holds the final
// write-back of the following tick. Synchronous reset clears the gain and
// target registers, the integral and velocity state and the result valid.
module pid_force_velocity_controller
    import pfvc_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [POS_W-1:0]     s_axis_tdata,  // [31:0] position
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata,  // [31:0] velocity_cmd
    output logic [0:0]           m_axis_tuser   // [0] saturated
);

    localparam int NCH = (DATA_WIDTH + CHUNK_W - 1) / CHUNK_W;

    t_dp_cmd cmd;

    pfvc_ctrl #(
        .NCH(NCH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    pfvc_dp #(
        .DATA_WIDTH(DATA_WIDTH),
        .FRAC_BITS (FRAC_BITS),
        .NCH       (NCH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pos      (signed'(s_axis_tdata)),
        .i_cmd      (cmd),
        .o_vel      (m_axis_tdata),
        .o_sat      (m_axis_tuser[0])
    );

endmodule
